// ===== rtl/gmm_pkg.sv =====
`default_nettype none
package gmm_pkg;
  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ACCUM = 2'd1,
    ACT_ADAPT = 2'd2,
    ACT_NONE  = 2'd3
  } gmm_action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_WAIT,
    ST_ACC,
    ST_MULT,
    ST_PREP,
    ST_DIV,
    ST_ROUND,
    ST_OUT
  } gmm_state_t;

  localparam logic [15:0] TAU_RESET = 16'd5120;
  localparam int MEAN_W = 48;
  localparam int WGT_W = 40;
  localparam int NUM_W = 58;
  localparam int DEN_W = 41;
  localparam logic signed [MEAN_W-1:0] MEAN_MAX = {1'b0, {(MEAN_W-1){1'b1}}};
  localparam logic signed [MEAN_W-1:0] MEAN_MIN = {1'b1, {(MEAN_W-1){1'b0}}};
endpackage
`default_nettype wire

// ===== rtl/gmm_map_mean_adaptation.sv =====
`default_nettype none
// MAP mean adaptation for diagonal Gaussian mixtures. Each input word carries an action:
// clear zeroes all statistics, accumulate adds posterior*feature (and, at dimension 0,
// the posterior and a had-data mark) for one element, adapt returns
// (16*tau*prior + acc)/(16*tau + weight) in Q8.8, rounded and saturated, or the prior
// mean when the element is out of range or its pdf has no data. Every input word gives
// one output word. Accumulate steps through memory read, one shared multiply, write back,
// output and idle; adapt runs a restoring divider retiring one quotient bit per cycle;
// clear sweeps the mean store of NUM_PDFS*NUM_COMPS*FEAT_DIM entries (32768 at defaults),
// one entry per cycle, and also runs once after reset while no input word is accepted.
// tau is written on the cfg channel while idle.
module gmm_map_mean_adaptation
  import gmm_pkg::*;
#(
  parameter int NUM_PDFS  = 64,
  parameter int NUM_COMPS = 8,
  parameter int FEAT_DIM  = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // action[1:0], pdf_index[7:2], comp_index[10:8], dim_index[16:11],
  // feature_value[32:17], posterior[48:33], prior_mean[64:49], zero fill
  input  wire logic [71:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // adapted_mean[15:0], had_data[16], saturated[17], zero fill
  output logic [23:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);
  localparam int PW = (NUM_PDFS > 1) ? $clog2(NUM_PDFS) : 1;
  localparam int CW = (NUM_COMPS > 1) ? $clog2(NUM_COMPS) : 1;
  localparam int DW = (FEAT_DIM > 1) ? $clog2(FEAT_DIM) : 1;
  localparam int WDEPTH = NUM_PDFS * NUM_COMPS;
  localparam int MDEPTH = WDEPTH * FEAT_DIM;
  localparam int WAW = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int MAW = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
  localparam int QW = NUM_W;

  gmm_state_t state_r, state_nxt;
  logic [15:0] tau_r;
  logic [1:0]  act_r;
  logic [5:0]  pdf_r;
  logic [2:0]  comp_r;
  logic [5:0]  dim_r;
  logic signed [15:0] feat_r, prior_r;
  logic [15:0] post_r;
  logic in_range_r;
  logic [NUM_PDFS-1:0] had_r;
  logic had_init_r;
  logic [MAW:0] clr_r;
  logic [6:0] cnt_r;
  logic signed [MEAN_W-1:0] macc_r;
  logic [WGT_W-1:0] wacc_r;
  logic signed [33:0] prod_r;
  logic [QW-1:0] rem_r, quo_r;
  logic [DEN_W-1:0] den_r;
  logic neg_r, has_r;
  logic [15:0] res_r;
  logic sat_r;

  logic [MAW-1:0] maddr;
  logic [WAW-1:0] waddr;
  logic m_we, w_we;
  logic [MAW-1:0] m_wa;
  logic [WAW-1:0] w_wa;
  logic [MEAN_W-1:0] m_wd, m_rd;
  logic [WGT_W-1:0] w_wd, w_rd;

  assign waddr = WAW'(PW'(pdf_r) * NUM_COMPS + CW'(comp_r));
  assign maddr = MAW'(waddr * FEAT_DIM + DW'(dim_r));

  gmm_ram #(.WIDTH(MEAN_W), .DEPTH(MDEPTH)) u_mean (
    .clk(clk), .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(maddr), .rdata(m_rd));
  gmm_ram #(.WIDTH(WGT_W), .DEPTH(WDEPTH)) u_wgt (
    .clk(clk), .we(w_we), .waddr(w_wa), .wdata(w_wd), .raddr(waddr), .rdata(w_rd));

  // shared multiplier: posterior*feature or tau*prior
  logic signed [16:0] mul_a;
  logic signed [15:0] mul_b;
  always_comb begin
    if (act_r == ACT_ADAPT) begin
      mul_a = $signed({1'b0, tau_r});
      mul_b = prior_r;
    end else begin
      mul_a = $signed({1'b0, post_r});
      mul_b = feat_r;
    end
  end

  logic signed [MEAN_W:0] msum;
  logic signed [MEAN_W-1:0] msat;
  logic [WGT_W:0] wsum;
  assign msum = {macc_r[MEAN_W-1], macc_r} + (MEAN_W+1)'(prod_r);
  always_comb begin
    if (msum > (MEAN_W+1)'(MEAN_MAX)) msat = MEAN_MAX;
    else if (msum < (MEAN_W+1)'(MEAN_MIN)) msat = MEAN_MIN;
    else msat = msum[MEAN_W-1:0];
  end
  assign wsum = {1'b0, wacc_r} + (WGT_W+1)'(post_r);

  logic signed [NUM_W-1:0] num;
  assign num = NUM_W'(prod_r) * 16 + NUM_W'(macc_r);

  logic [QW:0] rem_sh;
  logic [QW:0] rem_sub;
  assign rem_sh = {rem_r, quo_r[QW-1]};
  assign rem_sub = rem_sh - (QW+1)'(den_r);

  logic [QW-1:0] qr;
  assign qr = quo_r;

  always_comb begin
    m_we = 1'b0;
    m_wa = maddr;
    m_wd = msat;
    w_we = 1'b0;
    w_wa = waddr;
    w_wd = (wsum[WGT_W]) ? {WGT_W{1'b1}} : wsum[WGT_W-1:0];
    if (state_r == ST_CLEAR) begin
      m_we = 1'b1;
      m_wa = clr_r[MAW-1:0];
      m_wd = '0;
      w_we = clr_r < (MAW+1)'(WDEPTH);
      w_wa = clr_r[WAW-1:0];
      w_wd = '0;
    end else if (state_r == ST_ACC && act_r == ACT_ACCUM && in_range_r) begin
      m_we = 1'b1;
      w_we = dim_r == 6'd0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          case (gmm_action_t'(in_tdata[1:0]))
            ACT_CLEAR: state_nxt = ST_CLEAR;
            ACT_ACCUM, ACT_ADAPT: state_nxt = ST_READ;
            default: state_nxt = ST_OUT;
          endcase
        end
      end
      ST_CLEAR: if (clr_r == (MAW+1)'(MDEPTH - 1)) state_nxt = ST_OUT;
      ST_READ: state_nxt = ST_WAIT;
      ST_WAIT: state_nxt = ST_MULT;
      ST_MULT: state_nxt = (act_r == ACT_ADAPT) ? ST_PREP : ST_ACC;
      ST_ACC: state_nxt = ST_OUT;
      ST_PREP: state_nxt = ST_DIV;
      ST_DIV: if (cnt_r == 7'(QW - 1)) state_nxt = ST_ROUND;
      ST_ROUND: state_nxt = ST_OUT;
      ST_OUT: if (out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = state_r == ST_IDLE && clr_r == '0 && rst_n && !had_init_r;
    out_tvalid = state_r == ST_OUT;
    cfg_ready = state_r == ST_IDLE;
    out_tdata = {6'd0, sat_r, has_r, res_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      had_init_r <= 1'b1;
      clr_r <= '0;
      tau_r <= TAU_RESET;
      had_r <= '0;
    end else begin
      if (had_init_r) begin
        clr_r <= clr_r + 1'b1;
        if (clr_r == (MAW+1)'(MDEPTH - 1)) begin
          had_init_r <= 1'b0;
          clr_r <= '0;
          state_r <= ST_IDLE;
        end
      end else begin
        state_r <= state_nxt;
        if (state_r == ST_CLEAR) begin
          clr_r <= (clr_r == (MAW+1)'(MDEPTH - 1)) ? '0 : clr_r + 1'b1;
          had_r <= '0;
        end
        if (state_r == ST_ACC && act_r == ACT_ACCUM && in_range_r && dim_r == 6'd0) begin
          had_r[PW'(pdf_r)] <= 1'b1;
        end
      end
      if (cfg_valid && cfg_ready) tau_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        act_r <= in_tdata[1:0];
        pdf_r <= in_tdata[7:2];
        comp_r <= in_tdata[10:8];
        dim_r <= in_tdata[16:11];
        feat_r <= in_tdata[32:17];
        post_r <= in_tdata[48:33];
        prior_r <= in_tdata[64:49];
        in_range_r <= 32'(in_tdata[7:2]) < NUM_PDFS && 32'(in_tdata[10:8]) < NUM_COMPS
                      && 32'(in_tdata[16:11]) < FEAT_DIM;
        res_r <= '0;
        sat_r <= 1'b0;
        has_r <= 1'b0;
      end
      ST_WAIT: begin
        macc_r <= m_rd;
        wacc_r <= w_rd;
        prod_r <= 34'(mul_a * mul_b);
      end
      ST_MULT: begin
        has_r <= act_r == ACT_ADAPT && in_range_r && had_r[PW'(pdf_r)];
        res_r <= (act_r == ACT_ADAPT) ? prior_r : '0;
      end
      ST_PREP: begin
        neg_r <= num[NUM_W-1];
        quo_r <= num[NUM_W-1] ? QW'(-num) : QW'(num);
        rem_r <= '0;
        den_r <= DEN_W'({tau_r, 4'd0}) + DEN_W'(wacc_r);
        cnt_r <= '0;
      end
      ST_DIV: begin
        cnt_r <= cnt_r + 1'b1;
        if (!rem_sub[QW]) begin
          rem_r <= rem_sub[QW-1:0];
          quo_r <= {quo_r[QW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh[QW-1:0];
          quo_r <= {quo_r[QW-2:0], 1'b0};
        end
      end
      ST_ROUND: begin
        if (has_r && den_r != '0) begin
          // round half away: remainder*2 >= den
          if (neg_r) begin
            if (qr + QW'({rem_r, 1'b0} >= (QW+1)'(den_r)) > QW'(32768)) begin
              res_r <= 16'h8000; sat_r <= 1'b1;
            end else begin
              res_r <= 16'(-(qr + QW'({rem_r, 1'b0} >= (QW+1)'(den_r))));
            end
          end else begin
            if (qr + QW'({rem_r, 1'b0} >= (QW+1)'(den_r)) > QW'(32767)) begin
              res_r <= 16'h7FFF; sat_r <= 1'b1;
            end else begin
              res_r <= 16'(qr + QW'({rem_r, 1'b0} >= (QW+1)'(den_r)));
            end
          end
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/gmm_ram.sv =====
`default_nettype none
module gmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== bench/tb_gmm_map_mean_adaptation.sv =====
module tb_gmm_map_mean_adaptation;
  import gmm_pkg::*;

  localparam int LIMIT = 2000000;
  localparam int PRESS_LEN = 600;

  typedef struct {
    gmm_action_t      act;
    logic [5:0]       pdf;
    logic [2:0]       comp;
    logic [5:0]       dim;
    logic signed [15:0] feat;
    logic [15:0]      post;
    logic signed [15:0] prior;
  } gmm_word_t;

  typedef struct {
    logic signed [15:0] mean;
    logic               had;
    logic               sat;
  } mean_res_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic [71:0] in_tdata = '0;
  logic out_tready = 0;
  logic cfg_valid = 0;
  logic [15:0] cfg_data = '0;
  wire in_tready, out_tvalid, cfg_ready;
  wire [23:0] out_tdata;

  gmm_map_mean_adaptation u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // shadow copy of the statistics store
  localparam int NUM_ACC = 64 * 8 * 64;
  longint mean_sum [NUM_ACC];
  longint wgt_sum [512];
  bit pdf_seen [64];
  logic [15:0] tau_cur = TAU_RESET;

  gmm_word_t pending [$];
  mean_res_t mean_exp [$];
  gmm_word_t cur;
  logic drv_hold = 0;
  int in_gap = 0;
  int out_gap = 0;
  bit no_idle = 0;
  bit press_on = 0;
  int press_cnt = 0;
  int err_cnt = 0;
  int cycles = 0;
  int n_in = 0, n_out = 0, n_adapt = 0, n_had = 0, n_sat = 0, n_cfg = 0;
  logic [5:0] hot_pdf [4];

  task automatic wipe_stats();
    foreach (mean_sum[i]) mean_sum[i] = 0;
    foreach (wgt_sum[i]) wgt_sum[i] = 0;
    foreach (pdf_seen[i]) pdf_seen[i] = 0;
  endtask

  task automatic predict_mean(input gmm_word_t w);
    mean_res_t r;
    int wi, mi;
    longint s, num, den, mag, q;
    r = '{mean: 16'sd0, had: 1'b0, sat: 1'b0};
    wi = w.pdf * 8 + w.comp;
    mi = wi * 64 + w.dim;
    case (w.act)
      ACT_CLEAR: wipe_stats();
      ACT_ACCUM: begin
        s = mean_sum[mi] + longint'(w.post) * longint'(w.feat);
        if (s > 64'sh7FFF_FFFF_FFFF) s = 64'sh7FFF_FFFF_FFFF;
        if (s < -64'sh8000_0000_0000) s = -64'sh8000_0000_0000;
        mean_sum[mi] = s;
        if (w.dim == 0) begin
          s = wgt_sum[wi] + longint'(w.post);
          wgt_sum[wi] = (s > 64'hFF_FFFF_FFFF) ? 64'hFF_FFFF_FFFF : s;
          pdf_seen[w.pdf] = 1;
        end
      end
      ACT_ADAPT: begin
        r.mean = w.prior;
        r.had = pdf_seen[w.pdf];
        if (r.had) begin
          num = longint'(tau_cur) * longint'(w.prior) * 16 + mean_sum[mi];
          den = longint'(tau_cur) * 16 + wgt_sum[wi];
          if (den != 0) begin
            mag = (num < 0) ? -num : num;
            q = (mag + den / 2) / den;
            if (num < 0) begin
              if (q > 32768) begin
                r.mean = -16'sd32768;
                r.sat = 1;
              end else r.mean = 16'(-q);
            end else begin
              if (q > 32767) begin
                r.mean = 16'sd32767;
                r.sat = 1;
              end else r.mean = 16'(q);
            end
          end
        end
      end
      default: ;
    endcase
    mean_exp.push_back(r);
  endtask

  task automatic report(input string what, input int exp_v, input int got_v);
    $display("mismatch %s: expected %0d got %0d (result %0d)", what, exp_v, got_v, n_out);
    err_cnt++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_mean(cur);
        n_in++;
        drv_hold = 0;
        in_gap = no_idle ? 0 : $urandom_range(0, 13);
      end
      if (!drv_hold) begin
        if (in_gap > 0) in_gap--;
        else if (pending.size() > 0) begin
          cur = pending.pop_front();
          in_tdata <= {7'b0, cur.prior, cur.post, cur.feat, cur.dim, cur.comp, cur.pdf,
                       cur.act};
          drv_hold = 1;
        end
      end
      in_tvalid <= drv_hold;
    end
  end

  // monitor
  always @(posedge clk) begin
    mean_res_t e;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        n_out++;
        if (mean_exp.size() == 0) begin
          $display("unexpected result word %h", out_tdata);
          err_cnt++;
        end else begin
          e = mean_exp.pop_front();
          if (out_tdata[15:0] !== e.mean)
            report("adapted_mean", e.mean, $signed(out_tdata[15:0]));
          if (out_tdata[16] !== e.had) report("had_data", e.had, out_tdata[16]);
          if (out_tdata[17] !== e.sat) report("saturated", e.sat, out_tdata[17]);
          if (e.had) n_had++;
          if (e.sat) n_sat++;
        end
        out_gap = no_idle ? 0 : $urandom_range(0, 13);
      end else if (out_gap > 0) out_gap--;
      out_tready <= (out_gap == 0) && !press_on;
    end
  end

  always @(posedge clk) begin
    if (press_on) press_cnt <= press_cnt + 1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_gmm_map_mean_adaptation: errors");
      $finish;
    end
  end

  task automatic add(input gmm_action_t a, input int p, input int c, input int d,
                     input int f, input int po, input int pr);
    gmm_word_t w;
    w.act = a;
    w.pdf = 6'(p);
    w.comp = 3'(c);
    w.dim = 6'(d);
    w.feat = 16'(f);
    w.post = 16'(po);
    w.prior = 16'(pr);
    if (a == ACT_ADAPT) n_adapt++;
    pending.push_back(w);
  endtask

  task automatic wait_idle();
    wait (pending.size() == 0 && !drv_hold && mean_exp.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_tau(input logic [15:0] v);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    tau_cur = v;
    n_cfg++;
    cfg_valid <= 0;
  endtask

  task automatic rand_items(input int n);
    int k, p, c, nv, d;
    int dims [4];
    k = 0;
    while (k < n) begin
      if ($urandom_range(0, 99) < 15) begin
        // noise: unused code, stray adapt or stray accumulate anywhere
        case ($urandom_range(0, 2))
          0: add(ACT_NONE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
          1: add(ACT_ADAPT, $urandom, $urandom, $urandom, 0, 0, $urandom);
          default: add(ACT_ACCUM, $urandom, $urandom, $urandom, $urandom, $urandom, 0);
        endcase
        k++;
      end else begin
        p = ($urandom_range(0, 9) < 8) ? hot_pdf[$urandom_range(0, 3)] : $urandom_range(0, 63);
        c = $urandom_range(0, 7);
        dims[0] = 0;
        for (int i = 1; i < 4; i++)
          dims[i] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : i;
        nv = $urandom_range(1, 4);
        for (int v = 0; v < nv; v++) begin
          for (int i = 0; i < 4; i++) begin
            add(ACT_ACCUM, p, c, dims[i], $urandom,
                $urandom_range(0, 1) ? $urandom_range(0, 4095) : $urandom, 0);
            k++;
          end
        end
        for (int i = 0; i < 4; i++) begin
          d = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : dims[i];
          add(ACT_ADAPT, p, c, d, 0, 0, $urandom);
          k++;
        end
      end
    end
  endtask

  initial begin
    wipe_stats();
    foreach (hot_pdf[i]) hot_pdf[i] = 6'($urandom);
    repeat (9) @(posedge clk);
    rst_n <= 1;

    // default tau: extremes and plain cases
    add(ACT_ADAPT, 5, 1, 2, 0, 0, 1234);
    add(ACT_NONE, 63, 7, 63, -1, 65535, -1);
    add(ACT_ACCUM, 0, 0, 0, 32767, 65535, 0);
    add(ACT_ACCUM, 0, 0, 1, -32768, 65535, 0);
    add(ACT_ACCUM, 63, 7, 0, -32768, 4096, 0);
    add(ACT_ACCUM, 63, 7, 63, 32767, 4096, 0);
    add(ACT_ADAPT, 0, 0, 0, 0, 0, 32767);
    add(ACT_ADAPT, 0, 0, 1, 0, 0, -32768);
    add(ACT_ADAPT, 63, 7, 0, 0, 0, 0);
    add(ACT_ADAPT, 63, 7, 63, 0, 0, -1);
    add(ACT_ADAPT, 0, 3, 5, 0, 0, 100);
    add(ACT_CLEAR, 0, 0, 0, 0, 0, 0);
    add(ACT_ADAPT, 0, 0, 0, 0, 0, 777);
    wait_idle();

    // tau zero: zero denominator and clipping both ways
    write_tau(16'd0);
    add(ACT_ACCUM, 1, 0, 0, 500, 0, 0);
    add(ACT_ADAPT, 1, 0, 0, 0, 0, -300);
    add(ACT_ACCUM, 2, 0, 0, 0, 1, 0);
    add(ACT_ACCUM, 2, 0, 1, 32767, 65535, 0);
    add(ACT_ACCUM, 2, 0, 2, -32768, 65535, 0);
    add(ACT_ACCUM, 2, 0, 3, -32768, 1, 0);
    add(ACT_ADAPT, 2, 0, 1, 0, 0, 0);
    add(ACT_ADAPT, 2, 0, 2, 0, 0, 0);
    add(ACT_ADAPT, 2, 0, 3, 0, 0, 0);
    add(ACT_ADAPT, 2, 1, 0, 0, 0, 55);
    rand_items(180);
    wait_idle();

    write_tau(16'hFFFF);
    rand_items(150);
    wait_idle();

    // long output hold-off while inputs keep coming, then a stretch with no gaps
    write_tau(16'($urandom));
    add(ACT_CLEAR, 0, 0, 0, 0, 0, 0);
    wait_idle();
    rand_items(160);
    wait (mean_exp.size() > 0);
    press_on = 1;
    wait (press_cnt >= PRESS_LEN);
    press_on = 0;
    wait_idle();
    no_idle = 1;
    rand_items(100);
    wait_idle();
    no_idle = 0;

    write_tau(16'd1);
    rand_items(150);
    wait_idle();

    write_tau(TAU_RESET);
    rand_items(60);
    wait_idle();
    repeat (200) @(posedge clk);

    $display("%0d words in, %0d results, %0d adapts (%0d with data, %0d clipped), %0d tau writes",
             n_in, n_out, n_adapt, n_had, n_sat, n_cfg);
    if (err_cnt == 0 && mean_exp.size() == 0) begin
      $display("tb_gmm_map_mean_adaptation: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", err_cnt, mean_exp.size());
      $display("tb_gmm_map_mean_adaptation: errors");
    end
    $finish;
  end
endmodule
